>>> sv/thmm_pkg.sv
`timescale 1ns / 1ps
// thmm_pkg: shared types, constants and fixed-point helpers for the
// thruster mode mixer with heading-hold pid. no dependencies.
package thmm_pkg;

	// mode codes carried by each control tick
	typedef enum logic [2:0] {
		CMD_FOLLOW_OBJ  = 3'd0,
		CMD_FOLLOW_WALL = 3'd1,
		CMD_REMOTE      = 3'd2,
		CMD_EXPLORE     = 3'd3,
		CMD_UP          = 3'd4,
		CMD_DOWN        = 3'd5,
		CMD_STAY        = 3'd6,
		CMD_IDLE        = 3'd7
	} cmd_t;

	// configuration register indexes (paddr[3:2])
	localparam logic [1:0] REG_PROP_GAIN      = 2'd0;
	localparam logic [1:0] REG_RATE_GAIN      = 2'd1;
	localparam logic [1:0] REG_INTEG_GAIN     = 2'd2;
	localparam logic [1:0] REG_HEADING_TARGET = 2'd3;

	// register reset values
	localparam logic [15:0] PROP_GAIN_RST      = 16'd655;
	localparam logic [15:0] RATE_GAIN_RST      = 16'd328;
	localparam logic [15:0] INTEG_GAIN_RST     = 16'd0;
	localparam logic [14:0] HEADING_TARGET_RST = 15'd17920;

	// fixed-point constants, q2.14 and 1/64 degree
	localparam logic signed [17:0] SIZE_LIMIT = 18'sd3277;
	localparam logic signed [15:0] BACKOFF    = -16'sd819;
	localparam logic signed [15:0] ONE_Q14    = 16'sd16384;
	localparam logic signed [15:0] FULL_TURN  = 16'sd23040;
	localparam logic signed [15:0] HALF_TURN  = 16'sd11520;
	// 2^20 / 20 rounded up, exact for magnitudes up to 32768
	localparam logic [16:0] RECIP_20 = 17'd52429;

	// four thruster drives
	typedef struct packed {
		logic signed [15:0] va;
		logic signed [15:0] left;
		logic signed [15:0] right;
		logic signed [15:0] vb;
	} drive_t;

	// clamped pid terms, each within +-1.0
	typedef struct packed {
		logic signed [15:0] cp;
		logic signed [15:0] cd;
		logic signed [15:0] ci;
	} pid_terms_t;

	// saturate to the 16-bit signed range
	function automatic logic signed [15:0] sat16(input logic signed [17:0] x);
		logic signed [15:0] r;
		if (x > 18'sd32767) begin
			r = 16'sd32767;
		end else if (x < -18'sd32768) begin
			r = -16'sd32768;
		end else begin
			r = x[15:0];
		end
		return r;
	endfunction

	// clamp a floored product to +-1.0
	function automatic logic signed [15:0] clamp_q14(input logic signed [40:0] x);
		logic signed [15:0] r;
		if (x > 41'(ONE_Q14)) begin
			r = ONE_Q14;
		end else if (x < -41'(ONE_Q14)) begin
			r = -ONE_Q14;
		end else begin
			r = x[15:0];
		end
		return r;
	endfunction

	// divide by 20, truncating toward zero, via reciprocal multiply
	function automatic logic signed [15:0] div20(input logic signed [15:0] x);
		logic        neg;
		logic [16:0] mag;
		logic [33:0] prod;
		logic [15:0] q;
		neg  = x[15];
		mag  = neg ? (17'd0 - {x[15], x}) : {1'b0, x};
		prod = mag * RECIP_20;
		q    = {2'b00, prod[33:20]};
		return neg ? -$signed(q) : $signed(q);
	endfunction

	// divide by 2, truncating toward zero
	function automatic logic signed [15:0] half(input logic signed [15:0] x);
		logic signed [15:0] adj;
		adj = x + {15'd0, x[15]};
		return adj >>> 1;
	endfunction

endpackage

>>> sv/thmm_integ.sv
`timescale 1ns / 1ps
// thmm_integ: saturating 32-bit accumulator of yaw rate for the integral term.
// depends on thmm_pkg.
module thmm_integ
	import thmm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               update,
	input  logic signed [15:0] rate,
	output logic signed [31:0] integ_next
);

	logic signed [31:0] integ_q;
	logic signed [32:0] sum;

	// saturating add of the new rate sample
	always_comb begin
		sum = 33'(integ_q) + 33'(rate);
		if (sum[32] != sum[31]) begin
			integ_next = sum[32] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
		end else begin
			integ_next = sum[31:0];
		end
	end

	// accumulator register, moves only on heading-hold transfers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
		end else if (update) begin
			integ_q <= integ_next;
		end
	end

endmodule

>>> sv/thmm_pid.sv
`timescale 1ns / 1ps
// thmm_pid: heading error wrap and the three gain products of the pid,
// each floored and clamped to +-1.0. depends on thmm_pkg.
module thmm_pid
	import thmm_pkg::*;
(
	input  logic [15:0]        prop_gain,
	input  logic [15:0]        rate_gain,
	input  logic [15:0]        integ_gain,
	input  logic [14:0]        heading_target,
	input  logic [14:0]        yaw_angle,
	input  logic signed [15:0] yaw_rate,
	input  logic signed [31:0] integ,
	output pid_terms_t         terms
);

	logic signed [15:0] err_raw;
	logic signed [15:0] err_wrap;
	logic signed [31:0] prod_p;
	logic signed [32:0] prod_d;
	logic signed [48:0] prod_i;

	// wrap heading error into one turn around zero
	always_comb begin
		err_raw = $signed({1'b0, heading_target}) - $signed({1'b0, yaw_angle});
		if (err_raw >= HALF_TURN) begin
			err_wrap = err_raw - FULL_TURN;
		end else if (err_raw < -HALF_TURN) begin
			err_wrap = err_raw + FULL_TURN;
		end else begin
			err_wrap = err_raw;
		end
	end

	// gain products, unsigned gains against signed operands
	assign prod_p = $signed({1'b0, prop_gain}) * $signed(err_wrap[14:0]);
	assign prod_d = $signed({1'b0, rate_gain}) * yaw_rate;
	assign prod_i = $signed({1'b0, integ_gain}) * integ;

	// floor by 256 and clamp
	assign terms.cp = clamp_q14(41'(prod_p >>> 8));
	assign terms.cd = clamp_q14(41'(prod_d >>> 8));
	assign terms.ci = clamp_q14(41'(prod_i >>> 8));

endmodule

>>> sv/thmm_mix.sv
`timescale 1ns / 1ps
// thmm_mix: thruster drives for follow-object and remote modes, zero for the
// rest. depends on thmm_pkg.
module thmm_mix
	import thmm_pkg::*;
(
	input  logic [2:0]         cmd,
	input  logic signed [15:0] pilot_forward,
	input  logic signed [15:0] pilot_turn,
	input  logic signed [15:0] remote_depth,
	input  logic signed [15:0] obj_size,
	input  logic signed [15:0] obj_horizontal,
	input  logic signed [15:0] obj_vertical,
	output drive_t             drives
);

	logic signed [15:0] hor_20;
	logic signed [15:0] ver_20;
	logic signed [17:0] approach;
	logic signed [15:0] fwd_h;
	logic signed [15:0] turn_h;
	logic signed [15:0] depth_h;

	assign hor_20   = div20(obj_horizontal);
	assign ver_20   = div20(obj_vertical);
	assign approach = SIZE_LIMIT - 18'(obj_size);
	assign fwd_h    = half(pilot_forward);
	assign turn_h   = half(pilot_turn);
	assign depth_h  = half(remote_depth);

	// per-mode lane selection
	always_comb begin
		drives = '0;
		case (cmd_t'(cmd))
			CMD_FOLLOW_OBJ: begin
				if (18'(obj_size) < SIZE_LIMIT) begin
					drives.left  = sat16(approach + 18'(hor_20));
					drives.right = sat16(approach - 18'(hor_20));
					drives.va    = -ver_20;
					drives.vb    = -ver_20;
				end else begin
					drives.left  = BACKOFF;
					drives.right = BACKOFF;
				end
			end
			CMD_REMOTE: begin
				drives.left  = sat16(18'(fwd_h) + 18'(turn_h));
				drives.right = sat16(18'(fwd_h) - 18'(turn_h));
				drives.va    = depth_h;
				drives.vb    = depth_h;
			end
			default: begin
				drives = '0;
			end
		endcase
	end

endmodule

>>> sv/thruster_mode_mixer_heading_pid_core.sv
`timescale 1ns / 1ps
// Thruster mode mixer with heading-hold pid: one control tick in, four
// thruster drives out. Takes one transfer per clock while the output is not
// stalled; the input register, product stage and output register load in
// that order, and out_valid rises when the output register loads; output
// stall holds the pipeline in place. The yaw-rate integral is updated when the
// tick is accepted, so back-to-back heading-hold ticks see each other's
// contributions. No clearing pass after reset. Registers are to be written over
// the apb port only while the pipe is empty; the block does not enforce this.
// depends on thmm_pkg, thmm_integ, thmm_pid, thmm_mix.
module thruster_mode_mixer_heading_pid_core
	import thmm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// apb configuration port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	// input channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         cmd,
	input  logic signed [15:0] pilot_forward,
	input  logic signed [15:0] pilot_turn,
	input  logic signed [15:0] remote_depth,
	input  logic [14:0]        yaw_angle,
	input  logic signed [15:0] yaw_rate,
	input  logic signed [15:0] obj_size,
	input  logic signed [15:0] obj_horizontal,
	input  logic signed [15:0] obj_vertical,
	// output channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] drive_vertical_a,
	output logic signed [15:0] drive_left,
	output logic signed [15:0] drive_right,
	output logic signed [15:0] drive_vertical_b
);

	logic [15:0] prop_gain_q;
	logic [15:0] rate_gain_q;
	logic [15:0] integ_gain_q;
	logic [14:0] heading_target_q;
	logic        cfg_wr;

	logic in_fire, load_s2, load_out;
	logic v_s1, v_s2, out_valid_q;
	logic pid_mode;

	logic [2:0]         cmd_s1;
	logic signed [15:0] fwd_s1, turn_s1, depth_s1;
	logic [14:0]        yaw_s1;
	logic signed [15:0] rate_s1, size_s1, hor_s1, ver_s1;
	logic signed [31:0] integ_s1;
	logic signed [31:0] integ_next;

	pid_terms_t terms;
	drive_t     drives;
	pid_terms_t terms_s2;
	drive_t     drives_s2;
	logic       pid_s2;

	logic signed [17:0] ctrl_sum;
	logic signed [15:0] ctrl;
	drive_t             result;
	drive_t             out_q;

	// apb register file
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q      <= PROP_GAIN_RST;
			rate_gain_q      <= RATE_GAIN_RST;
			integ_gain_q     <= INTEG_GAIN_RST;
			heading_target_q <= HEADING_TARGET_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_PROP_GAIN:      prop_gain_q      <= pwdata[15:0];
				REG_RATE_GAIN:      rate_gain_q      <= pwdata[15:0];
				REG_INTEG_GAIN:     integ_gain_q     <= pwdata[15:0];
				REG_HEADING_TARGET: heading_target_q <= pwdata[14:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_PROP_GAIN:      prdata = {16'd0, prop_gain_q};
			REG_RATE_GAIN:      prdata = {16'd0, rate_gain_q};
			REG_INTEG_GAIN:     prdata = {16'd0, integ_gain_q};
			REG_HEADING_TARGET: prdata = {17'd0, heading_target_q};
			default:            prdata = '0;
		endcase
	end

	// pipeline flow control: a stage loads when the next one is free or moving
	assign load_out = v_s2 & (~out_valid_q | ~out_stall);
	assign load_s2  = v_s1 & (~v_s2 | load_out);
	assign in_stall = v_s1 & ~(~v_s2 | load_out);
	assign in_fire  = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1        <= in_fire | (v_s1 & ~load_s2);
			v_s2        <= load_s2 | (v_s2 & ~load_out);
			out_valid_q <= load_out | (out_valid_q & out_stall);
		end
	end

	// heading-hold modes
	always_comb begin
		case (cmd_t'(cmd)) inside
			CMD_UP, CMD_DOWN, CMD_STAY: pid_mode = 1'b1;
			default:                    pid_mode = 1'b0;
		endcase
	end

	// yaw-rate integral, advanced at heading-hold input transfers
	thmm_integ u_integ (
		.clk        (clk),
		.arst_n     (arst_n),
		.update     (in_fire & pid_mode),
		.rate       (yaw_rate),
		.integ_next (integ_next)
	);

	// stage 1: input register
	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_s1   <= cmd;
			fwd_s1   <= pilot_forward;
			turn_s1  <= pilot_turn;
			depth_s1 <= remote_depth;
			yaw_s1   <= yaw_angle;
			rate_s1  <= yaw_rate;
			size_s1  <= obj_size;
			hor_s1   <= obj_horizontal;
			ver_s1   <= obj_vertical;
			integ_s1 <= integ_next;
		end
	end

	// stage 2 logic: pid products and mode mixing
	thmm_pid u_pid (
		.prop_gain      (prop_gain_q),
		.rate_gain      (rate_gain_q),
		.integ_gain     (integ_gain_q),
		.heading_target (heading_target_q),
		.yaw_angle      (yaw_s1),
		.yaw_rate       (rate_s1),
		.integ          (integ_s1),
		.terms          (terms)
	);

	thmm_mix u_mix (
		.cmd            (cmd_s1),
		.pilot_forward  (fwd_s1),
		.pilot_turn     (turn_s1),
		.remote_depth   (depth_s1),
		.obj_size       (size_s1),
		.obj_horizontal (hor_s1),
		.obj_vertical   (ver_s1),
		.drives         (drives)
	);

	always_ff @(posedge clk) begin
		if (load_s2) begin
			terms_s2  <= terms;
			drives_s2 <= drives;
			pid_s2    <= (cmd_t'(cmd_s1) == CMD_UP) || (cmd_t'(cmd_s1) == CMD_DOWN) ||
				(cmd_t'(cmd_s1) == CMD_STAY);
		end
	end

	// stage 3 logic: pid sum and final lane select
	always_comb begin
		ctrl_sum = 18'(terms_s2.cp) + 18'(terms_s2.cd) + 18'(terms_s2.ci);
		if (ctrl_sum > 18'(ONE_Q14)) begin
			ctrl = ONE_Q14;
		end else if (ctrl_sum < -18'(ONE_Q14)) begin
			ctrl = -ONE_Q14;
		end else begin
			ctrl = ctrl_sum[15:0];
		end
		if (pid_s2) begin
			result.va    = '0;
			result.left  = ctrl;
			result.right = -ctrl;
			result.vb    = '0;
		end else begin
			result = drives_s2;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= result;
		end
	end

	assign out_valid        = out_valid_q;
	assign drive_vertical_a = out_q.va;
	assign drive_left       = out_q.left;
	assign drive_right      = out_q.right;
	assign drive_vertical_b = out_q.vb;

endmodule

>>> sv/thmm_checker.sv
`timescale 1ns / 1ps
// thmm_port_checks: port-level checks on the mixer core, bound to the top level.
// depends on thruster_mode_mixer_heading_pid_core.
module thmm_port_checks (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [15:0] drive_vertical_a,
	input logic signed [15:0] drive_left,
	input logic signed [15:0] drive_right,
	input logic signed [15:0] drive_vertical_b
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("out_valid dropped while stalled");

	// a stalled result keeps its drives
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(drive_left) && $stable(drive_right) &&
			$stable(drive_vertical_a) && $stable(drive_vertical_b))
		else $error("drives changed while stalled");

	// both vertical thrusters always get the same drive
	a_vert_equal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> drive_vertical_a == drive_vertical_b)
		else $error("vertical drives differ");

	// input back-pressure only comes from a stalled output
	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output back-pressure");

endmodule

bind thruster_mode_mixer_heading_pid_core thmm_port_checks u_port_checks (.*);

>>> tb/thmm_checker.sv
`timescale 1ns / 1ps
// thmm_checker: watches the apb port and both transfer channels of the thruster
// mode mixer, predicts the four drives of every tick and compares them in order.
// depends on thmm_pkg.
module thmm_checker
	import thmm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	input  logic [31:0]        prdata,
	input  logic               pready,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [2:0]         cmd,
	input  logic signed [15:0] pilot_forward,
	input  logic signed [15:0] pilot_turn,
	input  logic signed [15:0] remote_depth,
	input  logic [14:0]        yaw_angle,
	input  logic signed [15:0] yaw_rate,
	input  logic signed [15:0] obj_size,
	input  logic signed [15:0] obj_horizontal,
	input  logic signed [15:0] obj_vertical,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [15:0] drive_vertical_a,
	input  logic signed [15:0] drive_left,
	input  logic signed [15:0] drive_right,
	input  logic signed [15:0] drive_vertical_b,
	output int                 fail_count,
	output int                 pending,
	output int                 result_count
);

	// shadow registers and integral
	logic [15:0] kp_shadow;
	logic [15:0] kd_shadow;
	logic [15:0] ki_shadow;
	logic [14:0] heading_shadow;
	int          yaw_integral;

	// drives still owed by the block, oldest first
	drive_t      drive_q[$];

	longint      lft;
	longint      rgt;
	longint      vert;
	longint      err;
	longint      cp;
	longint      cd;
	longint      ci;
	longint      acc;
	logic [31:0] reg_view;
	drive_t      want;

	initial begin
		fail_count   = 0;
		pending      = 0;
		result_count = 0;
	end

	// one line per mismatch, capped so a broken block cannot flood the log
	task automatic report_mismatch(input string msg);
		fail_count++;
		if (fail_count <= 40) begin
			$display("error: %0t: %s", $realtime, msg);
		end
	endtask

	task automatic check_drive(input string name, input logic signed [15:0] got,
			input logic signed [15:0] exp_val);
		if (got !== exp_val) begin
			report_mismatch($sformatf("%s got %0d want %0d", name, got, exp_val));
		end
	endtask

	// clamp to +-1.0 in q2.14
	function automatic longint unit_clip(input longint x);
		longint lim;
		lim = longint'(ONE_Q14);
		return (x > lim) ? lim : ((x < -lim) ? -lim : x);
	endfunction

	// saturate to a 16-bit drive
	function automatic logic signed [15:0] to_drive(input longint x);
		longint y;
		y = (x > 32767) ? 32767 : ((x < -32768) ? -32768 : x);
		return y[15:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_shadow      = PROP_GAIN_RST;
			kd_shadow      = RATE_GAIN_RST;
			ki_shadow      = INTEG_GAIN_RST;
			heading_shadow = HEADING_TARGET_RST;
			yaw_integral   = 0;
			drive_q.delete();
			pending = 0;
		end else begin
			// register writes and readback
			if (psel && penable && pready) begin
				if (pwrite) begin
					case (paddr[3:2])
						REG_PROP_GAIN:      kp_shadow = pwdata[15:0];
						REG_RATE_GAIN:      kd_shadow = pwdata[15:0];
						REG_INTEG_GAIN:     ki_shadow = pwdata[15:0];
						REG_HEADING_TARGET: heading_shadow = pwdata[14:0];
						default: ;
					endcase
				end else begin
					case (paddr[3:2])
						REG_PROP_GAIN:      reg_view = {16'd0, kp_shadow};
						REG_RATE_GAIN:      reg_view = {16'd0, kd_shadow};
						REG_INTEG_GAIN:     reg_view = {16'd0, ki_shadow};
						default:            reg_view = {17'd0, heading_shadow};
					endcase
					if (prdata !== reg_view) begin
						report_mismatch($sformatf("read of register %0d got %0h want %0h",
							paddr[3:2], prdata, reg_view));
					end
				end
			end

			// input transfer: predict the drives of this tick
			if (in_valid && !in_stall) begin
				lft  = 0;
				rgt  = 0;
				vert = 0;
				case (cmd_t'(cmd))
					CMD_FOLLOW_OBJ: begin
						if (int'(obj_size) < int'(SIZE_LIMIT)) begin
							lft  = longint'(SIZE_LIMIT) - obj_size + (int'(obj_horizontal) / 20);
							rgt  = longint'(SIZE_LIMIT) - obj_size - (int'(obj_horizontal) / 20);
							vert = -(int'(obj_vertical) / 20);
						end else begin
							lft = BACKOFF;
							rgt = BACKOFF;
						end
					end
					CMD_REMOTE: begin
						lft  = (int'(pilot_forward) / 2) + (int'(pilot_turn) / 2);
						rgt  = (int'(pilot_forward) / 2) - (int'(pilot_turn) / 2);
						vert = int'(remote_depth) / 2;
					end
					CMD_UP, CMD_DOWN, CMD_STAY: begin
						// heading error wrapped into one turn around zero
						err = longint'(heading_shadow) - longint'(yaw_angle);
						while (err >= HALF_TURN) err = err - FULL_TURN;
						while (err < -HALF_TURN) err = err + FULL_TURN;
						cp = unit_clip((longint'(kp_shadow) * err) >>> 8);
						cd = unit_clip((longint'(kd_shadow) * yaw_rate) >>> 8);
						// saturating integral, new value feeds the term
						acc = longint'(yaw_integral) + yaw_rate;
						if (acc > 64'sd2147483647) acc = 64'sd2147483647;
						if (acc < -64'sd2147483648) acc = -64'sd2147483648;
						yaw_integral = int'(acc);
						ci  = unit_clip((longint'(ki_shadow) * yaw_integral) >>> 8);
						lft = unit_clip(cp + cd + ci);
						rgt = -lft;
					end
					default: ;
				endcase
				want.va    = to_drive(vert);
				want.left  = to_drive(lft);
				want.right = to_drive(rgt);
				want.vb    = to_drive(vert);
				drive_q.push_back(want);
			end

			// output transfer: compare with the oldest prediction
			if (out_valid && !out_stall) begin
				result_count++;
				if (drive_q.size() == 0) begin
					report_mismatch("drive result with no tick outstanding");
				end else begin
					want = drive_q.pop_front();
					check_drive("drive_vertical_a", drive_vertical_a, want.va);
					check_drive("drive_left", drive_left, want.left);
					check_drive("drive_right", drive_right, want.right);
					check_drive("drive_vertical_b", drive_vertical_b, want.vb);
				end
			end
			pending = drive_q.size();
		end
	end

endmodule

>>> tb/thruster_mode_mixer_heading_pid_core_tb.sv
`timescale 1ns / 1ps
// thruster_mode_mixer_heading_pid_core_tb: drives control ticks and register
// settings into the mixer core and reports the verdict of thmm_checker.
// depends on thmm_pkg, thmm_checker and the core.
module thruster_mode_mixer_heading_pid_core_tb;
	import thmm_pkg::*;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [3:0]         paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	logic               in_valid;
	logic               in_stall;
	logic [2:0]         cmd;
	logic signed [15:0] pilot_forward;
	logic signed [15:0] pilot_turn;
	logic signed [15:0] remote_depth;
	logic [14:0]        yaw_angle;
	logic signed [15:0] yaw_rate;
	logic signed [15:0] obj_size;
	logic signed [15:0] obj_horizontal;
	logic signed [15:0] obj_vertical;
	logic               out_valid;
	logic               out_stall;
	logic signed [15:0] drive_vertical_a;
	logic signed [15:0] drive_left;
	logic signed [15:0] drive_right;
	logic signed [15:0] drive_vertical_b;

	int fail_count;
	int pending;
	int result_count;
	int ticks_sent;
	int settings_used;
	bit calm;

	thruster_mode_mixer_heading_pid_core u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.cmd              (cmd),
		.pilot_forward    (pilot_forward),
		.pilot_turn       (pilot_turn),
		.remote_depth     (remote_depth),
		.yaw_angle        (yaw_angle),
		.yaw_rate         (yaw_rate),
		.obj_size         (obj_size),
		.obj_horizontal   (obj_horizontal),
		.obj_vertical     (obj_vertical),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.drive_vertical_a (drive_vertical_a),
		.drive_left       (drive_left),
		.drive_right      (drive_right),
		.drive_vertical_b (drive_vertical_b)
	);

	thmm_checker u_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.cmd              (cmd),
		.pilot_forward    (pilot_forward),
		.pilot_turn       (pilot_turn),
		.remote_depth     (remote_depth),
		.yaw_angle        (yaw_angle),
		.yaw_rate         (yaw_rate),
		.obj_size         (obj_size),
		.obj_horizontal   (obj_horizontal),
		.obj_vertical     (obj_vertical),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.drive_vertical_a (drive_vertical_a),
		.drive_left       (drive_left),
		.drive_right      (drive_right),
		.drive_vertical_b (drive_vertical_b),
		.fail_count       (fail_count),
		.pending          (pending),
		.result_count     (result_count)
	);

	// clock, 12 ns period
	initial clk = 1'b0;
	always #6 clk = ~clk;

	// hard limit on the run
	initial begin
		#1_000_000;
		$display("status: fail");
		$finish;
	end

	// one apb access, setup then access phase
	task automatic reg_access(input bit wr, input logic [1:0] idx, input logic [31:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// stop sending and wait until every drive result is back
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	// new register setting while the pipe is empty, unused upper bits random
	task automatic set_regs(input logic [15:0] kp, input logic [15:0] kd,
			input logic [15:0] ki, input logic [14:0] hdg);
		drain();
		reg_access(1'b1, REG_PROP_GAIN, {16'($urandom), kp});
		reg_access(1'b1, REG_RATE_GAIN, {16'($urandom), kd});
		reg_access(1'b1, REG_INTEG_GAIN, {16'($urandom), ki});
		reg_access(1'b1, REG_HEADING_TARGET, {17'($urandom), hdg});
		reg_access(1'b0, REG_PROP_GAIN, 32'd0);
		reg_access(1'b0, REG_RATE_GAIN, 32'd0);
		reg_access(1'b0, REG_INTEG_GAIN, 32'd0);
		reg_access(1'b0, REG_HEADING_TARGET, 32'd0);
		settings_used++;
	endtask

	// one tick transfer after a random gap
	task automatic send(input cmd_t c, input logic signed [15:0] fwd,
			input logic signed [15:0] turn, input logic signed [15:0] depth,
			input logic [14:0] yaw, input logic signed [15:0] rate,
			input logic signed [15:0] size, input logic signed [15:0] hor,
			input logic signed [15:0] ver);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 4);
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid       <= 1'b1;
		cmd            <= c;
		pilot_forward  <= fwd;
		pilot_turn     <= turn;
		remote_depth   <= depth;
		yaw_angle      <= yaw;
		yaw_rate       <= rate;
		obj_size       <= size;
		obj_horizontal <= hor;
		obj_vertical   <= ver;
		do @(posedge clk); while (in_stall);
		ticks_sent++;
	endtask

	// q2.14 value leaning on the extremes and on small magnitudes
	function automatic logic signed [15:0] rand16();
		logic signed [15:0] v;
		case ($urandom_range(0, 7))
			0:       v = -16'sd32768;
			1:       v = 16'sd32767;
			2:       v = 16'($urandom_range(0, 200)) - 16'sd100;
			default: v = 16'($urandom);
		endcase
		return v;
	endfunction

	// yaw mostly within one turn, sometimes beyond it
	function automatic logic [14:0] rand_yaw();
		return ($urandom_range(0, 7) == 0) ? 15'($urandom_range(23040, 32767))
			: 15'($urandom_range(0, 23039));
	endfunction

	// random tick, weighted toward the heading-hold modes
	task automatic rand_tick();
		cmd_t               c;
		logic signed [15:0] size;
		case ($urandom_range(0, 9))
			0, 1:    c = CMD_FOLLOW_OBJ;
			2, 3:    c = CMD_REMOTE;
			4, 5:    c = CMD_UP;
			6:       c = CMD_DOWN;
			7, 8:    c = CMD_STAY;
			default: c = cmd_t'(3'($urandom_range(0, 7)));
		endcase
		size = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(3274, 3280)) : rand16();
		send(c, rand16(), rand16(), rand16(), rand_yaw(), rand16(), size, rand16(),
			rand16());
	endtask

	// output side: random stall before each result
	initial begin
		int n;
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			n = calm ? 0 : $urandom_range(0, 4);
			repeat (n) begin
				@(negedge clk);
				out_stall <= 1'b1;
			end
			@(negedge clk);
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	// stimulus
	initial begin
		int ph;
		int i;
		int w;
		arst_n         = 1'b0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		in_valid       = 1'b0;
		cmd            = CMD_IDLE;
		pilot_forward  = '0;
		pilot_turn     = '0;
		remote_depth   = '0;
		yaw_angle      = '0;
		yaw_rate       = '0;
		obj_size       = '0;
		obj_horizontal = '0;
		obj_vertical   = '0;
		ticks_sent     = 0;
		settings_used  = 1;
		calm           = 1'b0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		// directed ticks under the reset gains
		// follow object: just under the size limit, at it, and far either side
		send(CMD_FOLLOW_OBJ, 0, 0, 0, 0, 0, 3276, 32767, -32768);
		send(CMD_FOLLOW_OBJ, 0, 0, 0, 0, 0, 3277, 32767, 32767);
		send(CMD_FOLLOW_OBJ, 0, 0, 0, 0, 0, 32767, -32768, -32768);
		send(CMD_FOLLOW_OBJ, 0, 0, 0, 0, 0, -32768, -32768, 32767);
		send(CMD_FOLLOW_OBJ, 0, 0, 0, 0, 0, 0, -21, 19);
		// modes that drive nothing
		send(CMD_FOLLOW_WALL, 32767, -32768, 32767, 23039, 32767, -32768, 32767, 32767);
		send(CMD_EXPLORE, -32768, 32767, -32768, 0, -32768, 0, -32768, -32768);
		send(CMD_IDLE, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
		// remote mixing, extremes and odd negatives
		send(CMD_REMOTE, 32767, 32767, -32768, 0, 0, 0, 0, 0);
		send(CMD_REMOTE, -32768, -32768, 32767, 0, 0, 0, 0, 0);
		send(CMD_REMOTE, -1, 1, -3, 0, 0, 0, 0, 0);
		send(CMD_REMOTE, 32767, -32768, -1, 0, 0, 0, 0, 0);
		// heading hold: zero error, extremes of yaw, both edges of the wrap
		send(CMD_UP, 0, 0, 0, 17920, 0, 0, 0, 0);
		send(CMD_UP, 0, 0, 0, 0, 0, 0, 0, 0);
		send(CMD_DOWN, 0, 0, 0, 23039, 0, 0, 0, 0);
		send(CMD_STAY, 0, 0, 0, 32767, 0, 0, 0, 0);
		send(CMD_UP, 0, 0, 0, 6400, 0, 0, 0, 0);
		send(CMD_DOWN, 0, 0, 0, 6401, 0, 0, 0, 0);
		send(CMD_STAY, 0, 0, 0, 17920, 32767, 0, 0, 0);
		send(CMD_DOWN, 0, 0, 0, 17920, -32768, 0, 0, 0);
		send(CMD_UP, 0, 0, 0, 17920, -1, 0, 0, 0);
		// let every result come back before going on
		drain();

		// random phases over several register settings
		for (ph = 0; ph < 6; ph++) begin
			case (ph)
				0: set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 15'd0);
				1: set_regs(16'd0, 16'd0, 16'd0, 15'd23039);
				2: set_regs(16'($urandom), 16'($urandom), 16'($urandom_range(1, 64)),
					15'($urandom));
				3: set_regs(16'($urandom), 16'($urandom), 16'($urandom),
					15'($urandom_range(23040, 32767)));
				4: set_regs(16'd1, 16'd1, 16'd1, 15'($urandom_range(0, 23039)));
				default: set_regs(16'($urandom_range(0, 2000)), 16'($urandom_range(0, 2000)),
					16'($urandom_range(0, 300)), 15'($urandom_range(0, 23039)));
			endcase
			for (i = 0; i < 80; i++) begin
				if (i % 25 == 0) calm = ($urandom_range(0, 2) == 0);
				if (i == 50) drain();
				rand_tick();
			end
		end

		// swing the integral hard one way, then the other, back to back
		set_regs(16'd655, 16'd328, 16'd1, 15'd17920);
		calm = 1'b1;
		for (i = 0; i < 30; i++) begin
			send(cmd_t'(3'($urandom_range(4, 6))), rand16(), rand16(), rand16(), rand_yaw(),
				32767, rand16(), rand16(), rand16());
		end
		for (i = 0; i < 60; i++) begin
			send(cmd_t'(3'($urandom_range(4, 6))), rand16(), rand16(), rand16(), rand_yaw(),
				-32768, rand16(), rand16(), rand16());
		end
		calm = 1'b0;
		for (i = 0; i < 30; i++) rand_tick();

		// wind down
		@(negedge clk);
		in_valid <= 1'b0;
		for (w = 0; w < 4000 && pending != 0; w++) @(negedge clk);
		repeat (8) @(posedge clk);
		if (pending != 0) begin
			$display("error: %0d drive results never arrived", pending);
		end
		$display("summary: %0d ticks sent, %0d drive results checked, %0d register settings",
			ticks_sent, result_count, settings_used);
		$display("summary: all modes, field extremes, heading wrap, integral swung both ways");
		if (fail_count == 0 && pending == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
